// ===== src/afc_pkg.sv =====
// Shared types, constants and codes for the box-versus-frustum cull block.
`default_nettype none

package afc_pkg;

  // Number of frustum planes that are stored and tested (1 to 6).
  localparam int PLANE_COUNT = 6;

  // Configuration register indexes.
  localparam int          CFG_IDX_W   = 3;
  localparam logic [2:0]  CFG_MARGIN  = 3'd6;
  localparam int          CFG_DATA_W  = 64;
  localparam logic [15:0] MARGIN_RESET = 16'd262;

  // Visibility codes.
  localparam logic [1:0] VIS_OUTSIDE   = 2'd0;
  localparam logic [1:0] VIS_INSIDE    = 2'd1;
  localparam logic [1:0] VIS_INTERSECT = 2'd2;

  // Q12.4 center, unsigned Q11.4 half extent, corner coordinate, product, distance.
  typedef logic signed [15:0] coord_t;
  typedef logic        [14:0] half_t;
  typedef logic signed [17:0] corner_t;
  typedef logic signed [33:0] prod_t;
  typedef logic signed [35:0] dist_t;
  typedef logic        [63:0] plane_t;

  // Load strobes for the three stages inside a plane unit.
  typedef struct packed {
    logic ld_corner;
    logic ld_prod;
    logic ld_test;
  } afc_adv_t;

endpackage

`default_nettype wire

// ===== src/afc_plane_eval.sv =====
// Far/near corner distance test of one box against one frustum plane.
`default_nettype none

module afc_plane_eval (
  input  wire                   clk_i,
  input  afc_pkg::afc_adv_t     adv_i,
  input  afc_pkg::coord_t [2:0] center_i,
  input  afc_pkg::half_t  [2:0] half_i,
  input  afc_pkg::plane_t       plane_i,
  input  wire  [15:0]           margin_i,
  output logic                  far_behind_o,
  output logic                  near_behind_o
);
  import afc_pkg::*;

  corner_t far_q  [3];
  corner_t near_q [3];
  prod_t   far_prod_q  [3];
  prod_t   near_prod_q [3];
  coord_t  nrm [3];
  dist_t   ofs_term;
  dist_t   lim;
  dist_t   far_dist;
  dist_t   near_dist;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nrm[a] = $signed(plane_i[16*a +: 16]);
    end
    ofs_term = {{6{plane_i[63]}}, plane_i[63:48], 14'd0};
    lim      = -$signed({20'd0, margin_i});
    far_dist  = ofs_term;
    near_dist = ofs_term;
    for (int a = 0; a < 3; a++) begin
      far_dist  = far_dist  + {{2{far_prod_q[a][33]}},  far_prod_q[a]};
      near_dist = near_dist + {{2{near_prod_q[a][33]}}, near_prod_q[a]};
    end
  end

  // Corner pick: far takes +half for n >= 0, near takes +half for n <= 0.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (adv_i.ld_corner) begin
        far_q[a]  <= nrm[a][15]
                   ? {{2{center_i[a][15]}}, center_i[a]} - {3'd0, half_i[a]}
                   : {{2{center_i[a][15]}}, center_i[a]} + {3'd0, half_i[a]};
        near_q[a] <= (nrm[a][15] || (nrm[a] == 16'sd0))
                   ? {{2{center_i[a][15]}}, center_i[a]} + {3'd0, half_i[a]}
                   : {{2{center_i[a][15]}}, center_i[a]} - {3'd0, half_i[a]};
      end
      if (adv_i.ld_prod) begin
        far_prod_q[a]  <= far_q[a]  * nrm[a];
        near_prod_q[a] <= near_q[a] * nrm[a];
      end
    end
    if (adv_i.ld_test) begin
      far_behind_o  <= far_dist  < lim;
      near_behind_o <= near_dist < lim;
    end
  end

endmodule

`default_nettype wire

// ===== src/aabb_frustum_cull.sv =====
// Top level: classifies streamed axis-aligned boxes against the frustum planes.
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   96     box center x/y/z, half extents x/y/z
// m_axis    out  8      visibility code
// cfg       in   64     plane registers 0..5, on-plane margin at index 6
//
// Four register stages: corner pick, products, distance sum and compare,
// visibility merge into the output register. One box is taken every cycle
// while s_axis_tready is high. A stall on m_axis backs up through the valid
// bits stage by stage; s_axis_tready drops only once all four stages hold a
// box. Reset clears the valid bits and loads the config registers with their reset values.
module aabb_frustum_cull (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // center_x[15:0], center_y[31:16], center_z[47:32],
  // half_x[62:48], half_y[77:63], half_z[92:78], zero fill above
  input  wire  [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // visibility[1:0], zero fill above
  output logic [7:0]  m_axis_tdata,
  input  wire                               cfg_we_i,
  input  wire  [afc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [afc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import afc_pkg::*;

  plane_t      plane_q [PLANE_COUNT];
  logic [15:0] margin_q;

  logic [3:0] vld_q;
  logic [3:0] rdy;
  afc_adv_t   adv;

  coord_t [2:0] center;
  half_t  [2:0] half;

  logic [PLANE_COUNT-1:0] far_behind;
  logic [PLANE_COUNT-1:0] near_behind;
  logic [1:0]             vis_q;

  // Unpack the box fields.
  assign center[0] = $signed(s_axis_tdata[15:0]);
  assign center[1] = $signed(s_axis_tdata[31:16]);
  assign center[2] = $signed(s_axis_tdata[47:32]);
  assign half[0]   = s_axis_tdata[62:48];
  assign half[1]   = s_axis_tdata[77:63];
  assign half[2]   = s_axis_tdata[92:78];

  // Configuration: writes beyond the register list are dropped.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        plane_q[p] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(p))) begin
        plane_q[p] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
    end else if (cfg_we_i && (cfg_idx_i == CFG_MARGIN)) begin
      margin_q <= cfg_wdata_i[15:0];
    end
  end

  // A stage may take new data when it is empty or its content moves on.
  always_comb begin
    rdy[3] = !vld_q[3] || m_axis_tready;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    adv.ld_corner = rdy[0] && s_axis_tvalid;
    adv.ld_prod   = rdy[1] && vld_q[0];
    adv.ld_test   = rdy[2] && vld_q[1];
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // One test unit per plane, all in lockstep.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    afc_plane_eval u_eval (
      .clk_i         (clk_i),
      .adv_i         (adv),
      .center_i      (center),
      .half_i        (half),
      .plane_i       (plane_q[p]),
      .margin_i      (margin_q),
      .far_behind_o  (far_behind[p]),
      .near_behind_o (near_behind[p])
    );
  end

  // Merge: any far corner behind wins, then any near corner behind.
  always_ff @(posedge clk_i) begin
    if (rdy[3] && vld_q[2]) begin
      if (|far_behind) begin
        vis_q <= VIS_OUTSIDE;
      end else if (|near_behind) begin
        vis_q <= VIS_INTERSECT;
      end else begin
        vis_q <= VIS_INSIDE;
      end
    end
  end

  assign m_axis_tvalid = vld_q[3];
  assign m_axis_tdata  = {6'd0, vis_q};

  // The code for three never leaves the block.
  a_vis_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("visibility code out of range");

  // Input backpressure only when every stage is occupied.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("input stalled with a free stage");

  // A ready sink lets the whole pipeline move.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // A result held under stall keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

`default_nettype wire
